@@ rtl/kinematic_bicycle_step_unit_defines.svh @@
// Assertion macros for the kinematic bicycle step unit.
`ifndef KINEMATIC_BICYCLE_STEP_UNIT_DEFINES_SVH
`define KINEMATIC_BICYCLE_STEP_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define KBS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define KBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define KBS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define KBS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/kbs_pkg.sv @@
// Types, constants and tables for the kinematic bicycle step unit.
`default_nettype none
package kbs_pkg;
    localparam int CORDIC_ITERATIONS      = 16;
    localparam int POSITION_FRACTION_BITS = 16;
    localparam int POS_SHIFT              = 32 - POSITION_FRACTION_BITS;
    localparam int CNT_W = ($clog2(CORDIC_ITERATIONS) > 4) ? $clog2(CORDIC_ITERATIONS) : 4;
    localparam int DIV_STEPS = 16;

    localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
    localparam logic [21:0]        TURNS_PER_RAD_Q24 = 22'd2670177;

    localparam logic [23:0] TIME_STEP_RST  = 24'd16777;
    localparam logic [15:0] INV_WB_RST     = 16'd14564;
    localparam logic [13:0] STEER_LIM_RST  = 14'd8192;
    localparam logic [31:0] Y_RST = 32'(64'd2 << POSITION_FRACTION_BITS);

    localparam logic [1:0] CFG_TIME_STEP   = 2'd0;
    localparam logic [1:0] CFG_INV_WB      = 2'd1;
    localparam logic [1:0] CFG_STEER_LIMIT = 2'd2;

    typedef struct packed {
        logic signed [15:0] speed_command;
        logic signed [15:0] steer_command;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [31:0]        heading_out;
        logic signed [15:0] velocity_x;
        logic signed [15:0] velocity_y;
        logic signed [15:0] turn_rate;
    } t_out_item;

    typedef enum logic [4:0] {
        S_IDLE, S_CORDH, S_HMAP, S_CORDS, S_SMAP, S_MVX, S_MVY, S_MA, S_MNUM,
        S_MX, S_MY, S_DIVCHK, S_DIV, S_TURN, S_MH1, S_MH2, S_MH3, S_HUPD
    } t_state;

    // arctan(2^-i) in 32-bit binary angle
    function automatic logic signed [33:0] atan_lut(input logic [4:0] i);
        logic signed [33:0] r;
        case (i)
            5'd0:  r = 34'sd536870912;
            5'd1:  r = 34'sd316933406;
            5'd2:  r = 34'sd167458907;
            5'd3:  r = 34'sd85004756;
            5'd4:  r = 34'sd42667331;
            5'd5:  r = 34'sd21354465;
            5'd6:  r = 34'sd10679838;
            5'd7:  r = 34'sd5340245;
            5'd8:  r = 34'sd2670163;
            5'd9:  r = 34'sd1335087;
            5'd10: r = 34'sd667544;
            5'd11: r = 34'sd333772;
            5'd12: r = 34'sd166886;
            5'd13: r = 34'sd83443;
            5'd14: r = 34'sd41722;
            5'd15: r = 34'sd20861;
            5'd16: r = 34'sd10430;
            5'd17: r = 34'sd5215;
            5'd18: r = 34'sd2608;
            5'd19: r = 34'sd1304;
            5'd20: r = 34'sd652;
            5'd21: r = 34'sd326;
            5'd22: r = 34'sd163;
            5'd23: r = 34'sd81;
            5'd24: r = 34'sd41;
            5'd25: r = 34'sd20;
            5'd26: r = 34'sd10;
            5'd27: r = 34'sd5;
            5'd28: r = 34'sd3;
            5'd29: r = 34'sd1;
            5'd30: r = 34'sd1;
            default: r = 34'sd0;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

@@ rtl/kinematic_bicycle_step_unit.sv @@
// Kinematic bicycle step unit: one Euler step per request.
// A new request is taken only after the previous one is finished; one CORDIC stage, one
// 33x33 multiplier and a 16-step restoring divider are reused in sequence.
// Input ready only in idle; a finished result waits in the output register.
// Synchronous active-low reset restores pose (0, 2 m, 0), steer 0 and register defaults.
`default_nettype none
`include "kinematic_bicycle_step_unit_defines.svh"
module kinematic_bicycle_step_unit
    import kbs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in_item    i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out_item        o_out_data,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [23:0] i_cfg_data
);
    t_state r_state, n_state;

    logic [23:0] r_dt;
    logic [15:0] r_invl;
    logic [13:0] r_lim;

    logic signed [31:0] r_x, r_y;
    logic [31:0]        r_heading;
    logic signed [15:0] r_steer;

    logic signed [15:0] r_v, r_st;
    logic [CNT_W-1:0]   r_cnt;
    logic signed [33:0] r_cx, r_cy, r_cz;
    logic [1:0]         r_q;
    logic signed [31:0] r_c, r_s, r_sc, r_ss;
    logic signed [63:0] r_prod, r_num, r_acc;
    logic signed [39:0] r_t;
    logic signed [15:0] r_vx, r_vy, r_turn;
    logic [31:0]        r_rem;
    logic [15:0]        r_dq;
    logic               r_neg, r_nz, r_ovf, r_scpos;
    logic               r_out_valid;
    t_out_item          r_out;

    logic in_acc, hupd_go, cordic_last, div_last;

    // ---------------- helpers ----------------
    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        logic signed [15:0] r;
        if (v > 64'sd32767)       r = 16'sh7fff;
        else if (v < -64'sd32768) r = 16'sh8000;
        else                      r = v[15:0];
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)       r = 32'sh7fffffff;
        else if (v < -64'sd2147483648) r = 32'sh80000000;
        else                           r = v[31:0];
        return r;
    endfunction

    // ---------------- CORDIC stage ----------------
    logic signed [33:0] dx, dy, atan_v;
    logic [31:0]        ang_sel, ang_sum, ang_red;
    logic [1:0]         ang_q;
    logic signed [31:0] map_c, map_s;

    always_comb begin
        dx     = r_cy >>> r_cnt;
        dy     = r_cx >>> r_cnt;
        atan_v = atan_lut(5'(r_cnt));
        ang_sel = (r_state == S_IDLE) ? r_heading : {r_steer, 16'h0000};
        ang_sum = ang_sel + 32'h2000_0000;
        ang_q   = ang_sum[31:30];
        ang_red = ang_sel - {ang_q, 30'd0};
        case (r_q)
            2'd0: begin map_c = r_cx[31:0];     map_s = r_cy[31:0];     end
            2'd1: begin map_c = -r_cy[31:0];    map_s = r_cx[31:0];     end
            2'd2: begin map_c = -r_cx[31:0];    map_s = -r_cy[31:0];    end
            default: begin map_c = r_cy[31:0];  map_s = -r_cx[31:0];    end
        endcase
    end

    // ---------------- shared multiplier ----------------
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic signed [16:0] v_ext;
    logic [16:0]        v_abs;

    always_comb begin
        v_ext = {r_v[15], r_v};
        v_abs = (v_ext < 0) ? 17'(-v_ext) : 17'(v_ext);
        case (r_state)
            S_MVX:  begin mul_a = 33'(r_v);              mul_b = 33'(r_c);            end
            S_MVY:  begin mul_a = 33'(r_v);              mul_b = 33'(r_s);            end
            S_MA:   begin mul_a = {16'd0, v_abs};        mul_b = {17'd0, r_invl};     end
            S_MNUM: begin mul_a = {1'b0, r_prod[31:0]};  mul_b = 33'(r_ss);           end
            S_MX:   begin mul_a = 33'(r_vx);             mul_b = {9'd0, r_dt};        end
            S_MY:   begin mul_a = 33'(r_vy);             mul_b = {9'd0, r_dt};        end
            S_MH1:  begin mul_a = 33'(r_turn);           mul_b = {9'd0, r_dt};        end
            S_MH2:  begin mul_a = {13'd0, r_prod[19:0]}; mul_b = {11'd0, TURNS_PER_RAD_Q24}; end
            // signed upper half; held while the result waits so the product stays put
            S_MH3, S_HUPD: begin
                mul_a = {{13{r_t[39]}}, r_t[39:20]};
                mul_b = {11'd0, TURNS_PER_RAD_Q24};
            end
            default: begin mul_a = '0;                   mul_b = '0;                  end
        endcase
        mul_p = mul_a * mul_b;
    end

    // ---------------- datapath helpers ----------------
    logic signed [63:0] vel_full, pos_step, pos_sum, y_sum, head_full, num_mag;
    logic [46:0]        div_d;
    logic [32:0]        rem2;
    logic               rem_ge;
    logic signed [15:0] turn_v, st_clamp, lim_s;

    always_comb begin
        vel_full = (r_prod + (64'sd1 <<< 29)) >>> 30;
        pos_step = (r_prod + (64'sd1 <<< (POS_SHIFT - 1))) >>> POS_SHIFT;
        pos_sum  = 64'(r_x) + pos_step;
        y_sum    = 64'(r_y) + pos_step;
        head_full = (r_prod <<< 20) + r_acc + (64'sd1 <<< 23);
        num_mag  = (r_num < 0) ? -r_num : r_num;
        div_d    = num_mag[62:16];
        rem2     = {r_rem, r_dq[15]};
        rem_ge   = rem2 >= {1'b0, r_sc};
        if (!r_scpos) begin
            turn_v = !r_nz ? 16'sd0 : (r_neg ? 16'sh8000 : 16'sh7fff);
        end else if (r_ovf) begin
            turn_v = r_neg ? 16'sh8000 : 16'sh7fff;
        end else if (r_neg) begin
            turn_v = (r_dq >= 16'd32768) ? 16'sh8000 : 16'(-$signed({1'b0, r_dq}));
        end else begin
            turn_v = (r_dq > 16'd32767) ? 16'sh7fff : $signed(r_dq);
        end
        lim_s = $signed({2'b00, r_lim});
        if (r_st > lim_s)       st_clamp = lim_s;
        else if (r_st < -lim_s) st_clamp = -lim_s;
        else                    st_clamp = r_st;
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = (r_state == S_IDLE);
        in_acc      = i_in_valid && o_in_ready;
        hupd_go     = !r_out_valid || i_out_ready;
        cordic_last = (r_cnt == CNT_W'(CORDIC_ITERATIONS - 1));
        div_last    = (r_cnt == CNT_W'(DIV_STEPS - 1));
        case (r_state)
            S_IDLE:   if (in_acc) n_state = S_CORDH;
            S_CORDH:  if (cordic_last) n_state = S_HMAP;
            S_HMAP:   n_state = S_CORDS;
            S_CORDS:  if (cordic_last) n_state = S_SMAP;
            S_SMAP:   n_state = S_MVX;
            S_MVX:    n_state = S_MVY;
            S_MVY:    n_state = S_MA;
            S_MA:     n_state = S_MNUM;
            S_MNUM:   n_state = S_MX;
            S_MX:     n_state = S_MY;
            S_MY:     n_state = S_DIVCHK;
            S_DIVCHK: n_state = S_DIV;
            S_DIV:    if (div_last) n_state = S_TURN;
            S_TURN:   n_state = S_MH1;
            S_MH1:    n_state = S_MH2;
            S_MH2:    n_state = S_MH3;
            S_MH3:    n_state = S_HUPD;
            S_HUPD:   if (hupd_go) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt        <= TIME_STEP_RST;
            r_invl      <= INV_WB_RST;
            r_lim       <= STEER_LIM_RST;
            r_x         <= '0;
            r_y         <= Y_RST;
            r_heading   <= '0;
            r_steer     <= '0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_TIME_STEP:   r_dt   <= i_cfg_data;
                    CFG_INV_WB:      r_invl <= i_cfg_data[15:0];
                    CFG_STEER_LIMIT: r_lim  <= i_cfg_data[13:0];
                    default: ;
                endcase
            end
            if (o_out_valid && i_out_ready) r_out_valid <= 1'b0;
            case (r_state)
                S_CORDH, S_CORDS, S_DIV: r_cnt <= (n_state == r_state) ? r_cnt + 1'b1 : '0;
                default: r_cnt <= '0;
            endcase
            if (r_state == S_MY)     r_x <= sat32(pos_sum);
            if (r_state == S_DIVCHK) r_y <= sat32(y_sum);
            if (r_state == S_HUPD && hupd_go) begin
                r_heading   <= r_heading + head_full[55:24];
                r_steer     <= st_clamp;
                r_out_valid <= 1'b1;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p[63:0];
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_v  <= i_in_data.speed_command;
                    r_st <= i_in_data.steer_command;
                end
                r_cx <= CORDIC_START;
                r_cy <= '0;
                r_cz <= 34'($signed(ang_red));
                r_q  <= ang_q;
            end
            S_CORDH, S_CORDS: begin
                if (!r_cz[33]) begin
                    r_cx <= r_cx - dx; r_cy <= r_cy + dy; r_cz <= r_cz - atan_v;
                end else begin
                    r_cx <= r_cx + dx; r_cy <= r_cy - dy; r_cz <= r_cz + atan_v;
                end
            end
            S_HMAP: begin
                r_c  <= map_c;
                r_s  <= map_s;
                r_cx <= CORDIC_START;
                r_cy <= '0;
                r_cz <= 34'($signed(ang_red));
                r_q  <= ang_q;
            end
            S_SMAP: begin
                r_sc <= map_c;
                r_ss <= map_s;
            end
            S_MVY:  r_vx  <= sat16(vel_full);
            S_MA:   r_vy  <= sat16(vel_full);
            S_MX:   r_num <= r_prod;
            S_DIVCHK: begin
                r_neg   <= r_num < 0;
                r_nz    <= r_num != 0;
                r_scpos <= !r_sc[31] && (r_sc != 0);
                r_ovf   <= div_d >= {r_sc[30:0], 16'd0};
                r_rem   <= {1'b0, div_d[46:16]};
                r_dq    <= div_d[15:0];
            end
            S_DIV: begin
                if (r_scpos && !r_ovf) begin
                    r_rem <= rem_ge ? 32'(rem2 - {1'b0, r_sc}) : rem2[31:0];
                    r_dq  <= {r_dq[14:0], rem_ge};
                end
            end
            S_TURN: r_turn <= turn_v;
            S_MH2:  r_t    <= r_prod[39:0];
            S_MH3:  r_acc  <= r_prod;
            S_HUPD: begin
                if (hupd_go) begin
                    r_out.pos_x       <= r_x;
                    r_out.pos_y       <= r_y;
                    r_out.heading_out <= r_heading + head_full[55:24];
                    r_out.velocity_x  <= r_vx;
                    r_out.velocity_y  <= r_vy;
                    r_out.turn_rate   <= r_turn;
                end
            end
            default: ;
        endcase
    end

    `KBS_ASSERT_NEXT(a_start, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == S_CORDH)
    `KBS_ASSERT_NEXT(a_result, i_clk, i_rst_n, r_state == S_HUPD && hupd_go, o_out_valid && r_state == S_IDLE)
    `KBS_ASSERT_IMPL(a_div_rem, i_clk, i_rst_n, r_state == S_DIV && r_scpos && !r_ovf, r_rem < r_sc)
endmodule
`default_nettype wire
